[sv/swmmm_pkg.sv]
// ----------------------------------------------------------------------------
// swmmm_pkg
// Shared types and constants of the sliding-window min/max/mean statistics.
// ----------------------------------------------------------------------------
package swmmm_pkg;

	// field widths
	localparam int SPEED_W = 8;
	localparam int CNT_W   = 5;
	// largest length the 5-bit register can select
	localparam int LEN_LIMIT = 31;
	// sum of up to LEN_LIMIT samples of 255
	localparam int TOTAL_W = 13;
	// quotient of the mean and the steps to build it
	localparam int QUO_W  = 8;
	localparam int STEP_W = 3;

	// window_length after reset
	localparam logic [CNT_W-1:0] WL_RESET = CNT_W'(16);

	// job queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// one finished window snapshot, waiting for its mean
	typedef struct packed {
		logic [SPEED_W-1:0] lo;
		logic [SPEED_W-1:0] hi;
		logic [TOTAL_W-1:0] total;
		logic [CNT_W-1:0]   count;
	} job_t;

endpackage

[sv/swmmm_front.sv]
// ----------------------------------------------------------------------------
// swmmm_front
// Accepts samples, updates the ring store, count and running total, then
// reduces the held samples to min and max, then pushes a job.
// ----------------------------------------------------------------------------
module swmmm_front #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swmmm_pkg::CNT_W-1:0]          cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [swmmm_pkg::SPEED_W-1:0]        wind_speed,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output swmmm_pkg::job_t                      push_job
);

	localparam int DEPTH = (MAX_WINDOW < swmmm_pkg::LEN_LIMIT) ? MAX_WINDOW
		: swmmm_pkg::LEN_LIMIT;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NGRP  = (DEPTH + 7) / 8;

	typedef enum logic [2:0] {
		F_IDLE   = 3'b001,
		F_REDUCE = 3'b010,
		F_PUSH   = 3'b100
	} fstate_t;

	fstate_t                               state_q;
	logic [swmmm_pkg::CNT_W-1:0]           wl_q;
	logic [swmmm_pkg::CNT_W-1:0]           fill_q;
	logic [swmmm_pkg::TOTAL_W-1:0]         total_q;
	logic [IDX_W-1:0]                      pos_q;
	logic [swmmm_pkg::SPEED_W-1:0]         store_q [DEPTH];

	logic [swmmm_pkg::SPEED_W-1:0]         glo_s1 [NGRP];
	logic [swmmm_pkg::SPEED_W-1:0]         ghi_s1 [NGRP];
	logic [swmmm_pkg::TOTAL_W-1:0]         total_s1;
	logic [swmmm_pkg::CNT_W-1:0]           fill_s1;

	logic                                  accept;
	logic [swmmm_pkg::CNT_W-1:0]           len;
	logic [IDX_W-1:0]                      pos_eff;
	logic [swmmm_pkg::CNT_W-1:0]           pos_inc;
	logic                                  full;
	logic [swmmm_pkg::TOTAL_W-1:0]         drop;
	logic [swmmm_pkg::SPEED_W-1:0]         glo_c [NGRP];
	logic [swmmm_pkg::SPEED_W-1:0]         ghi_c [NGRP];

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == F_IDLE);

	// effective window length, saturated to 1..DEPTH
	always_comb begin
		if (wl_q == '0) begin
			len = swmmm_pkg::CNT_W'(1);
		end else if (wl_q > swmmm_pkg::CNT_W'(DEPTH)) begin
			len = swmmm_pkg::CNT_W'(DEPTH);
		end else begin
			len = wl_q;
		end
	end

	// ring position and the sample that falls out when full
	always_comb begin
		pos_eff = (swmmm_pkg::CNT_W'(pos_q) >= len) ? '0 : pos_q;
		pos_inc = swmmm_pkg::CNT_W'(pos_eff) + 1'b1;
		full    = (fill_q >= len);
		drop    = full ? swmmm_pkg::TOTAL_W'(store_q[pos_eff]) : '0;
	end

	// control state, history bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wl_q    <= swmmm_pkg::WL_RESET;
			fill_q  <= '0;
			total_q <= '0;
			pos_q   <= '0;
		end else begin
			if (cfg_we) begin
				wl_q    <= cfg_wdata;
				fill_q  <= '0;
				total_q <= '0;
				pos_q   <= '0;
			end else if (accept) begin
				total_q <= total_q - drop + swmmm_pkg::TOTAL_W'(wind_speed);
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
				pos_q <= (pos_inc >= len) ? '0 : IDX_W'(pos_inc);
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_REDUCE;
					end
				end
				F_REDUCE: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (accept) begin
			store_q[pos_eff] <= wind_speed;
		end
	end

	// first reduction level: min and max within groups of eight
	always_comb begin
		int idx;
		for (int g = 0; g < NGRP; g++) begin
			glo_c[g] = '1;
			ghi_c[g] = '0;
			for (int j = 0; j < 8; j++) begin
				idx = g * 8 + j;
				if (idx < DEPTH && idx < int'(fill_q)) begin
					if (store_q[idx[IDX_W-1:0]] < glo_c[g]) begin
						glo_c[g] = store_q[idx[IDX_W-1:0]];
					end
					if (store_q[idx[IDX_W-1:0]] > ghi_c[g]) begin
						ghi_c[g] = store_q[idx[IDX_W-1:0]];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_REDUCE) begin
			glo_s1   <= glo_c;
			ghi_s1   <= ghi_c;
			total_s1 <= total_q;
			fill_s1  <= fill_q;
		end
	end

	// second level: combine the group results into the job
	always_comb begin
		push_job.lo    = '1;
		push_job.hi    = '0;
		push_job.total = total_s1;
		push_job.count = fill_s1;
		for (int g = 0; g < NGRP; g++) begin
			if (glo_s1[g] < push_job.lo) begin
				push_job.lo = glo_s1[g];
			end
			if (ghi_s1[g] > push_job.hi) begin
				push_job.hi = ghi_s1[g];
			end
		end
	end

	assign push_valid = (state_q == F_PUSH);

endmodule

[sv/swmmm_queue.sv]
// ----------------------------------------------------------------------------
// swmmm_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module swmmm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  swmmm_pkg::job_t push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output swmmm_pkg::job_t pop_job
);

	swmmm_pkg::job_t                ent_q [swmmm_pkg::QDEPTH];
	logic [swmmm_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [swmmm_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [swmmm_pkg::QCNT_W-1:0]   cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (cnt_q != swmmm_pkg::QCNT_W'(swmmm_pkg::QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = ent_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[sv/swmmm_back.sv]
// ----------------------------------------------------------------------------
// swmmm_back
// Takes jobs from the queue, divides the total by the count one quotient
// bit per cycle and holds the result until it is taken.
// ----------------------------------------------------------------------------
module swmmm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pop_valid,
	output logic                              pop_ready,
	input  swmmm_pkg::job_t                   pop_job,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [swmmm_pkg::SPEED_W-1:0]     lowest_speed,
	output logic [swmmm_pkg::SPEED_W-1:0]     highest_speed,
	output logic [swmmm_pkg::SPEED_W-1:0]     mean_speed,
	output logic [swmmm_pkg::CNT_W-1:0]       samples_held
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_OUT  = 3'b100
	} bstate_t;

	bstate_t                          state_q;
	logic [swmmm_pkg::STEP_W-1:0]     step_q;
	logic [swmmm_pkg::TOTAL_W-1:0]    rem_q;
	logic [swmmm_pkg::TOTAL_W-1:0]    div_q;
	logic [swmmm_pkg::QUO_W-1:0]      quo_q;
	logic [swmmm_pkg::SPEED_W-1:0]    lo_q;
	logic [swmmm_pkg::SPEED_W-1:0]    hi_q;
	logic [swmmm_pkg::CNT_W-1:0]      cnt_q;
	logic                             take;
	logic                             fits;

	assign pop_ready = (state_q == B_IDLE);
	assign take      = pop_valid && pop_ready;
	assign fits      = (rem_q >= div_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (take) begin
						state_q <= B_DIV;
						step_q  <= '0;
					end
				end
				B_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == '1) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// restoring divide, quotient MSB first; divisor starts shifted by 7
	always_ff @(posedge clk) begin
		if (take) begin
			rem_q <= pop_job.total;
			div_q <= swmmm_pkg::TOTAL_W'({pop_job.count, {(swmmm_pkg::QUO_W-1){1'b0}}});
			quo_q <= '0;
			lo_q  <= pop_job.lo;
			hi_q  <= pop_job.hi;
			cnt_q <= pop_job.count;
		end else if (state_q == B_DIV) begin
			if (fits) begin
				rem_q <= rem_q - div_q;
			end
			quo_q <= {quo_q[swmmm_pkg::QUO_W-2:0], fits};
			div_q <= div_q >> 1;
		end
	end

	assign out_valid     = (state_q == B_OUT);
	assign lowest_speed  = lo_q;
	assign highest_speed = hi_q;
	assign mean_speed    = quo_q;
	assign samples_held  = cnt_q;

endmodule

[sv/sliding_window_min_max_mean_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core
// Wind speed history with min, max, truncated mean and count per sample.
// ----------------------------------------------------------------------------
// Each accepted wind_speed request enters a ring history of the last
// window_length samples (0 acts as 1, lengths above MAX_WINDOW act as
// MAX_WINDOW) and yields one result: lowest, highest and truncated mean of
// the held samples, plus how many are held. Writing window_length clears
// the history and must only happen while the block is idle. The front
// takes a new sample only once it has stored the last one, run a two-level
// min/max reduction on it and handed a snapshot to a two-entry queue; the
// back divides the running total by the count one quotient bit per cycle
// in an 8-step divider and takes the next job once its result is taken.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_core #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swmmm_pkg::CNT_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [swmmm_pkg::SPEED_W-1:0]     wind_speed,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [swmmm_pkg::SPEED_W-1:0]     lowest_speed,
	output logic [swmmm_pkg::SPEED_W-1:0]     highest_speed,
	output logic [swmmm_pkg::SPEED_W-1:0]     mean_speed,
	output logic [swmmm_pkg::CNT_W-1:0]       samples_held
);

	logic            push_valid;
	logic            push_ready;
	swmmm_pkg::job_t push_job;
	logic            pop_valid;
	logic            pop_ready;
	swmmm_pkg::job_t pop_job;

	// history and min/max
	swmmm_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.wind_speed (wind_speed),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// job queue
	swmmm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// mean and result register
	swmmm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_job       (pop_job),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.lowest_speed  (lowest_speed),
		.highest_speed (highest_speed),
		.mean_speed    (mean_speed),
		.samples_held  (samples_held)
	);

endmodule

[verif/sliding_window_min_max_mean_checker.sv]
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_checker
// Watches the wind speed channels, predicts each result and compares it.
// ----------------------------------------------------------------------------
// Keeps its own ring history, fill count and running total. Each accepted
// wind_speed request queues the expected lowest, highest, mean and count.
// Each accepted result is checked against the oldest one in the queue.
// A window_length write clears the predicted history.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_checker
	import swmmm_pkg::*;
#(
	parameter int MAX_WINDOW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [SPEED_W-1:0] wind_speed,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [SPEED_W-1:0] lowest_speed,
	input  logic [SPEED_W-1:0] highest_speed,
	input  logic [SPEED_W-1:0] mean_speed,
	input  logic [CNT_W-1:0]   samples_held,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SPEED_W-1:0] lowest;
		logic [SPEED_W-1:0] highest;
		logic [SPEED_W-1:0] mean;
		logic [CNT_W-1:0]   held;
	} wind_stats_t;

	// predicted block state
	logic [SPEED_W-1:0] speed_history [MAX_WINDOW];
	int held_count;
	int speed_total;
	int write_slot;
	int window_len;

	wind_stats_t expected_stats [$];

	initial begin
		fail_count = 0;
		pending    = 0;
		for (int i = 0; i < MAX_WINDOW; i++)
			speed_history[i] = '0;
	end

	// zero acts as one, anything above the store size acts as the store size
	function automatic int active_window();
		int len;
		len = window_len;
		if (len < 1)
			len = 1;
		if (len > MAX_WINDOW)
			len = MAX_WINDOW;
		return len;
	endfunction

	task automatic forget_history();
		held_count  = 0;
		speed_total = 0;
		write_slot  = 0;
	endtask

	// add one sample to the ring and work out the statistics it reports
	task automatic absorb_speed(input logic [SPEED_W-1:0] speed, output wind_stats_t stats);
		int len;
		int lo;
		int hi;
		len = active_window();
		if (write_slot >= len)
			write_slot = 0;
		// full: the slot about to be written holds the oldest sample
		if (held_count >= len)
			speed_total -= speed_history[write_slot];
		else
			held_count++;
		speed_history[write_slot] = speed;
		speed_total += speed;
		write_slot++;
		if (write_slot >= len)
			write_slot = 0;
		lo = 255;
		hi = 0;
		for (int i = 0; i < held_count; i++) begin
			if (speed_history[i] < lo)
				lo = speed_history[i];
			if (speed_history[i] > hi)
				hi = speed_history[i];
		end
		stats.lowest  = SPEED_W'(lo);
		stats.highest = SPEED_W'(hi);
		stats.mean    = SPEED_W'(speed_total / held_count);
		stats.held    = CNT_W'(held_count);
	endtask

	// track config, predict on each request, compare on each result
	always @(posedge clk or negedge arst_n) begin
		wind_stats_t want;
		wind_stats_t seen;
		int bad;
		bad = 0;
		if (!arst_n) begin
			window_len = int'(WL_RESET);
			forget_history();
			expected_stats.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				window_len = int'(cfg_wdata);
				forget_history();
			end
			if (in_valid && in_ready) begin
				absorb_speed(wind_speed, want);
				expected_stats.push_back(want);
			end
			if (out_valid && out_ready) begin
				seen = '{lowest_speed, highest_speed, mean_speed, samples_held};
				if (expected_stats.size() == 0) begin
					$error("result with no request outstanding");
					bad++;
				end else begin
					want = expected_stats.pop_front();
					if (seen.lowest !== want.lowest) begin
						$error("lowest_speed: expected %0d, got %0d", want.lowest, seen.lowest);
						bad++;
					end
					if (seen.highest !== want.highest) begin
						$error("highest_speed: expected %0d, got %0d", want.highest,
							seen.highest);
						bad++;
					end
					if (seen.mean !== want.mean) begin
						$error("mean_speed: expected %0d, got %0d", want.mean, seen.mean);
						bad++;
					end
					if (seen.held !== want.held) begin
						$error("samples_held: expected %0d, got %0d", want.held, seen.held);
						bad++;
					end
				end
			end
			pending <= expected_stats.size();
			if (bad != 0)
				fail_count <= fail_count + bad;
		end
	end

endmodule

[verif/sliding_window_min_max_mean_core_test.sv]
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core_test
// Stimulus and verdict for the wind speed window statistics core.
// ----------------------------------------------------------------------------
// Runs a directed set of extreme speeds across the window length corner
// cases (zero, one, full store, beyond the store), then random phases of
// wind speed requests, each under a fresh window_length written while the
// core is idle. Both channels idle at random; the checker does the compare.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swmmm_pkg::*;

	localparam int WINDOW_MAX    = 16;
	localparam int SPEED_ITEMS   = 850;
	localparam int SETTLE_CYCLES = 30;
	localparam int CYCLE_LIMIT   = 600000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [SPEED_W-1:0] wind_speed = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [SPEED_W-1:0] lowest_speed;
	logic [SPEED_W-1:0] highest_speed;
	logic [SPEED_W-1:0] mean_speed;
	logic [CNT_W-1:0]   samples_held;

	int  fail_count;
	int  pending;
	int  cycle_count = 0;
	int  speeds_sent = 0;
	int  result_stall = 0;
	bit  calm = 1'b0;

	sliding_window_min_max_mean_core #(
		.MAX_WINDOW(WINDOW_MAX)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.wind_speed   (wind_speed),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.lowest_speed (lowest_speed),
		.highest_speed(highest_speed),
		.mean_speed   (mean_speed),
		.samples_held (samples_held)
	);

	sliding_window_min_max_mean_checker #(
		.MAX_WINDOW(WINDOW_MAX)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.wind_speed   (wind_speed),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.lowest_speed (lowest_speed),
		.highest_speed(highest_speed),
		.mean_speed   (mean_speed),
		.samples_held (samples_held),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sliding_window_min_max_mean_core: mismatch");
			$finish;
		end
	end

	// mostly short idle gaps, now and then a long one; none while calm
	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		if (result_stall > 0) begin
			out_ready <= 1'b0;
			result_stall <= result_stall - 1;
		end else begin
			out_ready <= 1'b1;
			result_stall <= idle_gap();
		end
	end

	function automatic logic [SPEED_W-1:0] pick_speed();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 4)
			return SPEED_W'($urandom_range(0, 7));
		return SPEED_W'($urandom_range(0, 255));
	endfunction

	// one wind_speed request; valid stays up across back-to-back requests
	task automatic send_speed(input logic [SPEED_W-1:0] speed);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		wind_speed <= speed;
		do
			@(posedge clk);
		while (!in_ready);
		speeds_sent++;
	endtask

	// drain every result, let the core settle, then write window_length
	task automatic set_window(input int len);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int pick_window();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return $urandom_range(17, 31);
		if (r < 4)
			return 1;
		if (r < 6)
			return WINDOW_MAX;
		return $urandom_range(1, WINDOW_MAX);
	endfunction

	initial begin
		int burst;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length of 16: extremes and alternating bit patterns
		send_speed(8'd0);
		send_speed(8'd255);
		send_speed(8'hAA);
		send_speed(8'h55);
		send_speed(8'd1);
		send_speed(8'd254);
		// length one: each sample replaces the last
		set_window(1);
		send_speed(8'd255);
		send_speed(8'd0);
		send_speed(8'd77);
		// zero acts as one
		set_window(0);
		send_speed(8'd200);
		send_speed(8'd3);
		// beyond the store: acts as the full store, wraps after 16
		set_window(31);
		for (int i = 0; i < 18; i++)
			send_speed(8'd255);
		set_window(17);
		send_speed(8'd9);
		send_speed(8'd10);
		// two: wrap on every other sample
		set_window(2);
		send_speed(8'd100);
		send_speed(8'd255);
		send_speed(8'd0);

		// random phases under fresh lengths
		while (speeds_sent < SPEED_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			set_window(pick_window());
			burst = $urandom_range(5, 60);
			for (int i = 0; i < burst; i++)
				send_speed(pick_speed());
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sliding_window_min_max_mean_core: match");
		else
			$display("sliding_window_min_max_mean_core: mismatch");
		$finish;
	end

endmodule
